[rtl/ttw_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// text-mode terminal writer. No dependencies.
package ttw_pkg;

    // Screen geometry and field widths
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int CELL_W     = CHAR_W + COLOR_W;

    localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CNT_COPY_END = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] CNT_END      = ADDR_W'(CELL_COUNT - 1);

    // Character codes and the attribute used by the power-up clearing pass
    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCROLL = 6'b000100,
        S_BLANK  = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;        // item taken this cycle
        logic copy;          // scroll copy step
        logic blank;         // blank the cell at the sweep counter
        logic blank_reset;   // blank with the power-up attribute
        logic cnt_step;
        logic cnt_zero;
        logic emit;          // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic put_scroll;    // a put item at the inputs would scroll
        logic cnt_copy_end;
        logic cnt_end;
        logic out_free;
    } status_t;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

endpackage

[rtl/ttw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ttw_ctrl.sv]
// Controller state machine of the terminal writer: sequences item accept,
// screen sweeps and result hand-off. Depends on ttw_pkg.
module ttw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        opcode,
    input  ttw_pkg::status_t  status,
    output logic              in_ready,
    output ttw_pkg::cmd_t     cmd
);
    import ttw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state; the clearing pass runs first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg) inside
            S_INIT:
            begin
                cmd.blank       = 1'b1;
                cmd.blank_reset = 1'b1;
                if (status.cnt_end)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.cnt_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (opcode_t'(opcode))
                        OP_PUT:   state_next = status.put_scroll ? S_SCROLL : S_EMIT;
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_READ:  state_next = S_EMIT;
                        OP_NONE:  state_next = S_EMIT;
                        default:  state_next = S_EMIT;
                    endcase
                end
            end
            S_SCROLL:
            begin
                cmd.copy = 1'b1;
                if (status.cnt_copy_end)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cmd.cnt_step = 1'b1;
                end
            end
            S_BLANK, S_CLEAR:
            begin
                cmd.blank = 1'b1;
                if (status.cnt_end)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.cnt_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

[rtl/ttw_datapath.sv]
// Datapath of the terminal writer: cursor, color register, sweep counter,
// screen store and result register. Depends on ttw_pkg and ttw_ram.
module ttw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttw_pkg::cmd_t                 cmd,
    output ttw_pkg::status_t              status,
    input  logic [1:0]                    opcode,
    input  logic [ttw_pkg::CHAR_W-1:0]    char_code,
    input  logic [ttw_pkg::ROW_W-1:0]     read_row,
    input  logic [ttw_pkg::COL_W-1:0]     read_column,
    input  logic                          text_color_we,
    input  logic [ttw_pkg::COLOR_W-1:0]   text_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttw_pkg::CHAR_W-1:0]    cell_char,
    output logic [ttw_pkg::COLOR_W-1:0]   cell_color,
    output logic [ttw_pkg::ROW_W-1:0]     cursor_row,
    output logic [ttw_pkg::COL_W-1:0]     cursor_column,
    output logic                          scrolled
);
    import ttw_pkg::*;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COLOR_W-1:0] color_reg;
    logic [ADDR_W-1:0]  cnt_reg;
    logic               read_hit_reg;
    logic               scrolled_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_scrolled_reg;

    logic               put_we;
    logic [ROW_W-1:0]   put_row;
    logic [COL_W-1:0]   put_col;
    logic [CHAR_W-1:0]  put_char;
    logic [ROW_W-1:0]   put_row_next;
    logic [COL_W-1:0]   put_col_next;
    logic               put_scroll;
    logic               read_hit;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;
    logic [COLOR_W-1:0] blank_color;

    // Put character: cell write and cursor move
    always_comb
    begin
        put_we       = 1'b0;
        put_row      = row_reg;
        put_col      = col_reg;
        put_char     = CH_SPACE;
        put_row_next = row_reg;
        put_col_next = col_reg;
        put_scroll   = 1'b0;
        if (char_code == CH_NEWLINE)
        begin
            put_col_next = '0;
            if (row_reg == ROW_LAST)
            begin
                put_scroll = 1'b1;
            end
            else
            begin
                put_row_next = row_reg + ROW_W'(1);
            end
        end
        else if (char_code == CH_BACKSPACE)
        begin
            if (col_reg != '0)
            begin
                put_we       = 1'b1;
                put_col      = col_reg - COL_W'(1);
                put_col_next = col_reg - COL_W'(1);
            end
            else if (row_reg != '0)
            begin
                put_we       = 1'b1;
                put_row      = row_reg - ROW_W'(1);
                put_col      = COL_LAST;
                put_row_next = row_reg - ROW_W'(1);
                put_col_next = COL_LAST;
            end
        end
        else
        begin
            put_we   = 1'b1;
            put_char = char_code;
            if (col_reg == COL_LAST)
            begin
                put_col_next = '0;
                if (row_reg == ROW_LAST)
                begin
                    put_scroll = 1'b1;
                end
                else
                begin
                    put_row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                put_col_next = col_reg + COL_W'(1);
            end
        end
    end

    assign read_hit = (opcode_t'(opcode) == OP_READ) &&
                      (32'(read_row) < ROWS) && (32'(read_column) < COLUMNS);

    // Cursor after an accepted item
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.accept)
        begin
            case (opcode_t'(opcode))
                OP_PUT:
                begin
                    row_next = put_row_next;
                    col_next = put_col_next;
                end
                OP_CLEAR:
                begin
                    row_next = '0;
                    col_next = '0;
                end
                default:
                begin
                    row_next = row_reg;
                    col_next = col_reg;
                end
            endcase
        end
    end

    // Screen store port selection: item access, scroll copy or blanking sweep
    assign blank_color = cmd.blank_reset ? RESET_COLOR : color_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = {blank_color, CH_SPACE};
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(cnt_reg + ADDR_W'(COLUMNS));
        if (cmd.accept)
        begin
            ram_we    = put_we && (opcode_t'(opcode) == OP_PUT);
            ram_waddr = cell_addr(put_row, put_col);
            ram_wdata = {color_reg, put_char};
            ram_re    = read_hit;
            ram_raddr = cell_addr(read_row, read_column);
        end
        else if (cmd.copy)
        begin
            ram_we    = (cnt_reg != '0);
            ram_waddr = cnt_reg - ADDR_W'(1);
            ram_wdata = ram_rdata;
            ram_re    = !status.cnt_copy_end;
        end
        else if (cmd.blank)
        begin
            ram_we = 1'b1;
        end
    end

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers: cursor, color, sweep counter, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= RESET_COLOR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (text_color_we)
            begin
                color_reg <= text_color;
            end
            if (cmd.cnt_zero)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_step)
            begin
                cnt_reg <= cnt_reg + ADDR_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item flags and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            read_hit_reg <= read_hit;
            scrolled_reg <= (opcode_t'(opcode) == OP_PUT) && put_scroll;
        end
        if (cmd.emit)
        begin
            out_char_reg  <= read_hit_reg ? ram_rdata[CHAR_W-1:0] : '0;
            out_color_reg <= read_hit_reg ? ram_rdata[CELL_W-1:CHAR_W] : '0;
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
        end
    end

    // A scrolled flag must also reach the result; load it with the payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign status.put_scroll   = put_scroll;
    assign status.cnt_copy_end = (cnt_reg == CNT_COPY_END);
    assign status.cnt_end      = (cnt_reg == CNT_END);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign cell_char     = out_char_reg;
    assign cell_color    = out_color_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_column = out_col_reg;
    assign scrolled      = out_scrolled_reg;

endmodule

[rtl/text_mode_terminal_writer.sv]
// Top level of the text-mode terminal writer: controller plus datapath.
// Depends on ttw_pkg, ttw_ctrl, ttw_datapath (and through it ttw_ram).

// Teletype writer for a 25 x 80 character-cell screen held in one
// single-write, single-read RAM. After reset a clearing pass
// fills every cell with a space in attribute 0x0F; no item is accepted during
// it, though color writes are taken. An item is handled one at a time: a put
// that does not scroll, a read and an unused opcode accept with the RAM access,
// then load the result; a clear makes one RAM write per cell, and a put that
// scrolls copies the screen up one row at one read and one write per cycle,
// then blanks the 80 cells of the bottom row.
// The next item is accepted as soon as a result is loaded, while that result
// waits in the output register; a result stalls only if the previous one has
// not been taken.
module text_mode_terminal_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [ttw_pkg::CHAR_W-1:0]    char_code,
    input  logic [ttw_pkg::ROW_W-1:0]     read_row,
    input  logic [ttw_pkg::COL_W-1:0]     read_column,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttw_pkg::CHAR_W-1:0]    cell_char,
    output logic [ttw_pkg::COLOR_W-1:0]   cell_color,
    output logic [ttw_pkg::ROW_W-1:0]     cursor_row,
    output logic [ttw_pkg::COL_W-1:0]     cursor_column,
    output logic                          scrolled,
    input  logic                          text_color_we,
    input  logic [ttw_pkg::COLOR_W-1:0]   text_color
);
    import ttw_pkg::*;

    cmd_t    cmd;
    status_t status;

    ttw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    ttw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_column   (read_column),
        .text_color_we (text_color_we),
        .text_color    (text_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_char     (cell_char),
        .cell_color    (cell_color),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .scrolled      (scrolled)
    );

    // No item is taken while a sweep or copy owns the screen store
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.copy || cmd.blank))
        else $error("item accepted during a screen sweep");

    // A result is loaded only when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over an untaken result");

    // A clear item starts the blanking sweep at the first cell
    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_CLEAR)) |=> (cmd.blank && !in_ready))
        else $error("clear item did not start a sweep");

    // A loaded result shows up as valid in the next cycle
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("loaded result not presented");

endmodule
